>>> rtl/core/npe_pkg.sv
// ----------------------------------------------------------------------------
// Palette expander package
// Shared types and constants of the 4bpp image to RGB565 expander.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package npe_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BG = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FG = 2'd1;

  localparam logic [15:0] BG_RESET = 16'h18A2;
  localparam logic [15:0] FG_RESET = 16'hF79D;

  // "TIM4", first byte in the lowest lane
  localparam logic [3:0][7:0] MAGIC_WORD = {8'h34, 8'h4D, 8'h49, 8'h54};

  // Entries of the queue between parser and expander (power of two)
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_PAIR   = 2'd0,
    KIND_CLEAR  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_HDR  = 2'd1,
    ST_TRUNC    = 2'd2,
    ST_BAD_SIZE = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [9:0]  screen_x;
    logic [9:0]  screen_y;
    logic [15:0] left_pixel;
    logic [15:0] right_pixel;
    status_e     status_code;
    logic        final_result;
  } out_t;

  // Work for the expander: a pair or a clear, optionally followed by a status, or a status alone
  typedef struct packed {
    logic       has_pair;
    logic       has_clear;
    logic       has_status;
    status_e    code;
    logic [7:0] pixels;
    logic [9:0] x;
    logic [9:0] y;
  } cmd_t;

  // Palette read request, two nibbles per pixel byte
  typedef struct packed {
    logic       en;
    logic [3:0] idx_l;
    logic [3:0] idx_r;
  } pal_rd_t;

endpackage

`default_nettype wire

>>> rtl/core/npe_palette.sv
// ----------------------------------------------------------------------------
// Palette expander gradient table
// Color registers, 16-entry gradient memory rebuilt by a sweep, two read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module npe_palette (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [npe_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  wire logic [15:0]                        cfg_data_i,
  input  wire npe_pkg::pal_rd_t                   rd_i,
  output logic [15:0]                             rd_left_o,
  output logic [15:0]                             rd_right_o,
  output logic [15:0]                             bg_color_o,
  output logic                                    busy_o
);
  import npe_pkg::*;

  // floor(a / 15) = (a * 2185) >> 15 for a below 1024
  localparam logic [11:0] RECIP_15  = 12'd2185;
  localparam int unsigned QUO_SHIFT = 15;

  logic [15:0] bg_q, fg_q;
  logic        busy_q;
  logic [3:0]  idx_q;
  logic [9:0]  acc_q [3];
  logic [9:0]  acc_d [3];

  logic [5:0]  ch_from [3];
  logic [5:0]  ch_to   [3];
  logic [6:0]  ch_diff [3];
  logic [5:0]  ch_mag  [3];
  logic [21:0] ch_prod [3];
  logic [5:0]  ch_val  [3];
  logic [15:0] entry;
  logic        cfg_hit;

  logic [15:0] mem [16];
  logic [15:0] rd_left_q, rd_right_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_hit     = cfg_valid_i && (cfg_index_i == CFG_BG || cfg_index_i == CFG_FG);

  always_comb begin
    ch_from[0] = {1'b0, bg_q[15:11]};
    ch_from[1] = bg_q[10:5];
    ch_from[2] = {1'b0, bg_q[4:0]};
    ch_to[0]   = {1'b0, fg_q[15:11]};
    ch_to[1]   = fg_q[10:5];
    ch_to[2]   = {1'b0, fg_q[4:0]};
    for (int c = 0; c < 3; c++) begin
      ch_diff[c] = {1'b0, ch_to[c]} - {1'b0, ch_from[c]};
      ch_mag[c]  = ch_diff[c][6] ? 6'(-ch_diff[c]) : ch_diff[c][5:0];
      ch_prod[c] = 22'(acc_q[c]) * 22'(RECIP_15);
      // truncate toward zero: step from the start color by the magnitude
      ch_val[c]  = ch_diff[c][6] ? ch_from[c] - ch_prod[c][QUO_SHIFT+5:QUO_SHIFT]
                                 : ch_from[c] + ch_prod[c][QUO_SHIFT+5:QUO_SHIFT];
      acc_d[c]   = acc_q[c] + 10'(ch_mag[c]);
    end
    entry = {ch_val[0][4:0], ch_val[1], ch_val[2][4:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q   <= BG_RESET;
      fg_q   <= FG_RESET;
      busy_q <= 1'b1;
      idx_q  <= '0;
      for (int c = 0; c < 3; c++) acc_q[c] <= '0;
    end else if (cfg_hit) begin
      if (cfg_index_i == CFG_BG) bg_q <= cfg_data_i;
      else                       fg_q <= cfg_data_i;
      // restart the rebuild from entry zero
      busy_q <= 1'b1;
      idx_q  <= '0;
      for (int c = 0; c < 3; c++) acc_q[c] <= '0;
    end else if (busy_q) begin
      idx_q <= idx_q + 4'd1;
      for (int c = 0; c < 3; c++) acc_q[c] <= acc_d[c];
      if (idx_q == 4'd15) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) mem[idx_q] <= entry;
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_left_q  <= mem[rd_i.idx_l];
      rd_right_q <= mem[rd_i.idx_r];
    end
  end

  assign rd_left_o  = rd_left_q;
  assign rd_right_o = rd_right_q;
  assign bg_color_o = bg_q;
  assign busy_o     = busy_q;

endmodule

`default_nettype wire

>>> rtl/core/npe_front.sv
// ----------------------------------------------------------------------------
// Palette expander parser
// Accepts file bytes, checks the header and turns each pixel byte into expander work.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module npe_front #(
  parameter int unsigned PANEL_WIDTH  = 156,
  parameter int unsigned PANEL_HEIGHT = 240,
  parameter int unsigned PANEL_LEFT   = 164
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire npe_pkg::in_t in_data_i,
  output logic              in_stall_o,
  input  wire logic         busy_i,
  input  wire logic         full_i,
  output logic              push_o,
  output npe_pkg::cmd_t     cmd_o
);
  import npe_pkg::*;

  localparam logic [15:0] PW16 = 16'(PANEL_WIDTH);
  localparam logic [15:0] PH16 = 16'(PANEL_HEIGHT);
  localparam logic [10:0] PW11 = 11'(PANEL_WIDTH);
  localparam logic [10:0] PH11 = 11'(PANEL_HEIGHT);
  localparam logic [9:0]  PL10 = 10'(PANEL_LEFT);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PIXELS,
    PH_DISCARD,
    PH_TRAILING
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  pos_q, pos_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [9:0]  col_q, col_d;
  logic [9:0]  row_q, row_d;
  logic [9:0]  xb_q, xb_d;
  logic [9:0]  yb_q, yb_d;

  logic        accept;
  logic [7:0]  d;
  logic        eof;
  logic [15:0] hdr_h;
  logic        bad_size, undersize;
  logic [10:0] w_span, h_span;
  logic        last_col, last_row, done;
  cmd_t        cmd;

  assign in_stall_o = busy_i || full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign d          = in_data_i.data_byte;
  assign eof        = in_data_i.end_of_file;

  always_comb begin
    hdr_h     = {d, height_q[7:0]};
    bad_size  = (width_q == '0) || (hdr_h == '0) || width_q[0] ||
                (width_q > PW16) || (hdr_h > PH16);
    undersize = (width_q < PW16) || (hdr_h < PH16);
    w_span    = PW11 - width_q[10:0];
    h_span    = PH11 - hdr_h[10:0];
    last_col  = ({1'b0, col_q} + 11'd1) >= {1'b0, width_q[10:1]};
    last_row  = ({1'b0, row_q} + 11'd1) >= height_q[10:0];
    done      = last_col && last_row;
  end

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    xb_d     = xb_q;
    yb_d     = yb_q;
    cmd      = '0;
    if (accept) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (pos_q < 3'd4 && d != MAGIC_WORD[pos_q[1:0]]) begin
            cmd.has_status = 1'b1;
            cmd.code       = ST_BAD_HDR;
            phase_d        = eof ? PH_HEADER : PH_DISCARD;
            pos_d          = '0;
          end else if (pos_q != 3'd7) begin
            unique case (pos_q)
              3'd4:    width_d  = {8'h00, d};
              3'd5:    width_d  = {d, width_q[7:0]};
              3'd6:    height_d = {8'h00, d};
              default: ;
            endcase
            if (eof) begin
              cmd.has_status = 1'b1;
              cmd.code       = ST_BAD_HDR;
              pos_d          = '0;
            end else begin
              pos_d = pos_q + 3'd1;
            end
          end else begin
            height_d = hdr_h;
            pos_d    = '0;
            if (bad_size) begin
              cmd.has_status = 1'b1;
              cmd.code       = ST_BAD_SIZE;
              phase_d        = eof ? PH_HEADER : PH_DISCARD;
            end else begin
              cmd.has_clear = undersize;
              cmd.x         = PL10;
              if (eof) begin
                cmd.has_status = 1'b1;
                cmd.code       = ST_TRUNC;
              end else begin
                phase_d = PH_PIXELS;
                col_d   = '0;
                row_d   = '0;
                xb_d    = PL10 + w_span[10:1];
                yb_d    = h_span[10:1];
              end
            end
          end
        end
        PH_PIXELS: begin
          cmd.has_pair = 1'b1;
          cmd.pixels   = d;
          cmd.x        = xb_q + {col_q[8:0], 1'b0};
          cmd.y        = yb_q + row_q;
          if (last_col) begin
            col_d = '0;
            if (!last_row) row_d = row_q + 10'd1;
          end else begin
            col_d = col_q + 10'd1;
          end
          if (eof) begin
            cmd.has_status = 1'b1;
            cmd.code       = done ? ST_OK : ST_TRUNC;
            phase_d        = PH_HEADER;
            col_d          = '0;
            row_d          = '0;
          end else if (done) begin
            phase_d = PH_TRAILING;
          end
        end
        PH_TRAILING: begin
          if (eof) begin
            cmd.has_status = 1'b1;
            cmd.code       = ST_OK;
            phase_d        = PH_HEADER;
          end
        end
        PH_DISCARD: begin
          if (eof) phase_d = PH_HEADER;
        end
        default: phase_d = PH_HEADER;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      pos_q    <= '0;
      width_q  <= '0;
      height_q <= '0;
      col_q    <= '0;
      row_q    <= '0;
      xb_q     <= '0;
      yb_q     <= '0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      xb_q     <= xb_d;
      yb_q     <= yb_d;
    end
  end

  assign push_o = cmd.has_pair || cmd.has_clear || cmd.has_status;
  assign cmd_o  = cmd;

endmodule

`default_nettype wire

>>> rtl/core/npe_queue.sv
// ----------------------------------------------------------------------------
// Palette expander work queue
// Short FIFO of work between the parser and the expander.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module npe_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire npe_pkg::cmd_t push_data_i,
  input  wire logic          pop_i,
  output npe_pkg::cmd_t      pop_data_o,
  output logic               empty_o,
  output logic               full_o
);
  import npe_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign empty_o    = (count_q == '0);
  assign full_o     = (count_q == CNT_W'(QUEUE_DEPTH));
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      if (push_i && !pop_i)      count_q <= count_q + CNT_W'(1);
      else if (pop_i && !push_i) count_q <= count_q - CNT_W'(1);
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("queue count did not advance on push");
`endif

endmodule

`default_nettype wire

>>> rtl/core/npe_back.sv
// ----------------------------------------------------------------------------
// Palette expander output stage
// Looks up pixel colors and sends one or two results per unit of work.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module npe_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  wire npe_pkg::cmd_t q_data_i,
  output logic               pop_o,
  output npe_pkg::pal_rd_t   rd_o,
  input  wire logic [15:0]   rd_left_i,
  input  wire logic [15:0]   rd_right_i,
  input  wire logic [15:0]   bg_color_i,
  output logic               out_valid_o,
  output npe_pkg::out_t      out_data_o,
  input  wire logic          out_stall_i
);
  import npe_pkg::*;

  logic  a_valid_q;
  logic  a_second_q;
  cmd_t  a_cmd_q;
  logic  out_valid_q;
  out_t  out_q;

  logic  out_free, a_send, a_last, a_done;
  out_t  res;

  assign out_free = !out_valid_q || !out_stall_i;
  assign a_send   = a_valid_q && out_free;
  assign a_last   = a_second_q ||
                    !(a_cmd_q.has_status && (a_cmd_q.has_pair || a_cmd_q.has_clear));
  assign a_done   = a_send && a_last;
  assign pop_o    = q_valid_i && (!a_valid_q || a_done);

  assign rd_o.en    = pop_o;
  assign rd_o.idx_l = q_data_i.pixels[7:4];
  assign rd_o.idx_r = q_data_i.pixels[3:0];

  always_comb begin
    res = '0;
    if (a_second_q || !(a_cmd_q.has_pair || a_cmd_q.has_clear)) begin
      res.kind         = KIND_STATUS;
      res.status_code  = a_cmd_q.code;
      res.final_result = 1'b1;
    end else if (a_cmd_q.has_pair) begin
      res.kind        = KIND_PAIR;
      res.screen_x    = a_cmd_q.x;
      res.screen_y    = a_cmd_q.y;
      res.left_pixel  = rd_left_i;
      res.right_pixel = rd_right_i;
      res.status_code = ST_OK;
    end else begin
      res.kind        = KIND_CLEAR;
      res.screen_x    = a_cmd_q.x;
      res.left_pixel  = bg_color_i;
      res.right_pixel = bg_color_i;
      res.status_code = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      a_second_q  <= 1'b0;
      a_cmd_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      priority if (pop_o) begin
        a_valid_q  <= 1'b1;
        a_second_q <= 1'b0;
        a_cmd_q    <= q_data_i;
      end else if (a_done) begin
        a_valid_q  <= 1'b0;
        a_second_q <= 1'b0;
      end else if (a_send) begin
        // first of two results went out, status follows
        a_second_q <= 1'b1;
      end else begin
        a_valid_q <= a_valid_q;
      end
      if (a_send) begin
        out_valid_q <= 1'b1;
        out_q       <= res;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_second_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_second_q |-> a_valid_q && a_cmd_q.has_status)
    else $error("second result without pending status");
  a_second_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_send && !a_last) |=> a_second_q)
    else $error("status of a two-result transaction lost");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> q_valid_i) else $error("pop without queued work");
`endif

endmodule

`default_nettype wire

>>> rtl/core/nibble_image_palette_expander.sv
// ----------------------------------------------------------------------------
// Nibble image palette expander
// Parses a 4bpp image file and emits centered RGB565 pixel pairs, clears and status.
// ----------------------------------------------------------------------------
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall   npe_pkg::in_t  (byte, end flag)
//   out       output     out_valid / out_stall npe_pkg::out_t (pair/clear/status)
//   cfg       input      cfg_valid / cfg_ready index 0 background, 1 foreground
//
// One file byte per cycle while in_stall is low; a byte that yields two results holds
// the output stage for a second result, and the 4-entry work queue absorbs that.
// After reset and after each color write the 16-entry gradient table is
// rebuilt one entry per cycle, and input is stalled until it is done.
// in_stall rises while the table rebuilds or the work queue is full.
// A result waits in the output register while out_stall is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nibble_image_palette_expander #(
  parameter int unsigned PANEL_WIDTH  = 156,
  parameter int unsigned PANEL_HEIGHT = 240,
  parameter int unsigned PANEL_LEFT   = 164
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  input  wire npe_pkg::in_t                    in_data_i,
  output logic                                 in_stall_o,
  output logic                                 out_valid_o,
  output npe_pkg::out_t                        out_data_o,
  input  wire logic                            out_stall_i,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [npe_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [15:0]                     cfg_data_i
);
  import npe_pkg::*;

  logic        busy, q_full, q_empty, push, pop;
  cmd_t        push_cmd, head_cmd;
  pal_rd_t     rd;
  logic [15:0] rd_left, rd_right, bg_color;

  npe_palette u_palette (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rd_i        (rd),
    .rd_left_o   (rd_left),
    .rd_right_o  (rd_right),
    .bg_color_o  (bg_color),
    .busy_o      (busy)
  );

  npe_front #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .PANEL_LEFT   (PANEL_LEFT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .busy_i     (busy),
    .full_i     (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  npe_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .pop_data_o  (head_cmd),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  npe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (!q_empty),
    .q_data_i    (head_cmd),
    .pop_o       (pop),
    .rd_o        (rd),
    .rd_left_i   (rd_left),
    .rd_right_i  (rd_right),
    .bg_color_i  (bg_color),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

`default_nettype wire
